[rtl/core/nat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_pkg - shared types, tables and helpers for the accidental tracker
// Key patterns, accidental codes, the queue item and the key selection logic.
// ----------------------------------------------------------------------------
package nat_pkg;

    localparam int NOTE_COUNT  = 128;
    localparam int NOTE_W      = 7;
    localparam int MEASURE_W   = 16;
    localparam int ACC_W       = 2;
    localparam int CFG_W       = 3;
    localparam int MAP_AW      = $clog2(NOTE_COUNT);
    localparam int BANK_DEPTH  = (NOTE_COUNT + 1) / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int KEY_LEN     = 12;
    localparam int KEY_OFFSET  = 3;
    localparam int SHARP_MAX   = 5;
    localparam int FLAT_MAX    = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // reciprocal of 12 for values up to 130: floor(v * 171 / 2048)
    localparam int RECIP_MUL   = 171;
    localparam int RECIP_SHIFT = 11;
    localparam int PROD_W      = NOTE_W + 10;

    typedef enum logic [ACC_W-1:0] {
        ACC_NONE    = 2'd0,
        ACC_SHARP   = 2'd1,
        ACC_FLAT    = 2'd2,
        ACC_NATURAL = 2'd3
    } acc_t;

    typedef enum logic {
        REG_SHARP_COUNT = 1'b0,
        REG_FLAT_COUNT  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] sharp_count;
        logic [CFG_W-1:0] flat_count;
    } key_cfg_t;

    typedef struct packed {
        logic             flat;
        logic [CFG_W-1:0] row;
    } key_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              reload;
    } item_t;

    // entry k of a row sits at bits [2k+1:2k]
    localparam logic [2*KEY_LEN-1:0] SHARP_PAT [0:SHARP_MAX] = '{
        24'h441104, 24'h431104, 24'h4310C4,
        24'h3310C4, 24'h330CC4, 24'h330CC3
    };

    localparam logic [2*KEY_LEN-1:0] FLAT_PAT [0:FLAT_MAX] = '{
        24'h882208, 24'h882230, 24'h88C230, 24'h08C233,
        24'h08CC33, 24'h30CC33, 24'h30CCC3
    };

    // (note + 3) mod 12 by reciprocal multiply and a subtraction
    function automatic logic [3:0] key_pos(input logic [NOTE_W-1:0] note);
        logic [NOTE_W:0]   v;
        logic [PROD_W-1:0] prod;
        logic [3:0]        q;
        logic [NOTE_W:0]   r;
        v    = {1'b0, note} + (NOTE_W + 1)'(KEY_OFFSET);
        prod = PROD_W'(v) * PROD_W'(RECIP_MUL);
        q    = 4'(prod >> RECIP_SHIFT);
        r    = v - (NOTE_W + 1)'((NOTE_W + 1)'(q) * (NOTE_W + 1)'(KEY_LEN));
        return 4'(r);
    endfunction

    // clamp the counts and pick the flat or sharp pattern row
    function automatic key_t key_of(input key_cfg_t cfg);
        key_t k;
        k.flat = (cfg.flat_count != '0);
        if (k.flat)
            k.row = (cfg.flat_count > CFG_W'(FLAT_MAX)) ? CFG_W'(FLAT_MAX) : cfg.flat_count;
        else
            k.row = (cfg.sharp_count > CFG_W'(SHARP_MAX)) ? CFG_W'(SHARP_MAX)
                                                          : cfg.sharp_count;
        return k;
    endfunction

    function automatic acc_t pattern_entry(input key_t k, input logic [NOTE_W-1:0] note);
        logic [2*KEY_LEN-1:0] row_bits;
        logic [2*KEY_LEN-1:0] shifted;
        row_bits = k.flat ? FLAT_PAT[k.row] : SHARP_PAT[k.row];
        shifted  = row_bits >> {key_pos(note), 1'b0};
        return acc_t'(shifted[ACC_W-1:0]);
    endfunction

endpackage

[rtl/core/nat_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_queue - two-entry item queue
// Decouples the classifying front end from the map update back end.
// ----------------------------------------------------------------------------
module nat_queue
    import nat_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  not_empty,
    output logic  full
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/nat_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_front - input side of the accidental tracker
// Accepts note beats and flags the ones that start a new measure.
// ----------------------------------------------------------------------------
module nat_front
    import nat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [NOTE_W-1:0]    note_number,
    input  logic [MEASURE_W-1:0] measure_index,
    input  logic                 q_full,
    output logic                 in_stall,
    output logic                 push,
    output item_t                push_item
);

    logic                 loaded_reg;
    logic [MEASURE_W-1:0] last_measure_reg;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // first beat after reset or a new measure reloads the key map
    always_comb
    begin
        push_item.note   = note_number;
        push_item.reload = !loaded_reg || (measure_index != last_measure_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg       <= 1'b0;
            last_measure_reg <= '0;
        end
        else if (push)
        begin
            loaded_reg       <= 1'b1;
            last_measure_reg <= measure_index;
        end
    end

endmodule

[rtl/core/nat_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_back - accidental map lookup and update
// Two-bank map, dirty bits over key pattern; one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
module nat_back
    import nat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  item_t            head,
    output logic             pop,
    input  key_cfg_t         cfg,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [ACC_W-1:0] accidental
);

    // even and odd notes live in separate banks, so a note and its
    // neighbor never collide on a write port
    logic [ACC_W-1:0] even_mem [BANK_DEPTH];
    logic [ACC_W-1:0] odd_mem  [BANK_DEPTH];

    logic [NOTE_COUNT-1:0] dirty_reg;
    logic [NOTE_COUNT-1:0] dirty_next;
    key_t                  key_reg;

    logic              s1_valid_reg;
    logic [NOTE_W-1:0] s1_note_reg;
    logic              s1_inrange_reg;
    logic              s1_use_mem_reg;
    acc_t              s1_base_reg;
    logic [ACC_W-1:0]  rd_even_reg;
    logic [ACC_W-1:0]  rd_odd_reg;

    logic             out_valid_reg;
    logic [ACC_W-1:0] acc_reg;

    logic              s1_adv;
    acc_t              s1_acc;
    logic              main_wen;
    logic              nb_wen;
    logic [NOTE_W-1:0] nb_addr;
    acc_t              nb_val;
    logic              up_ok;
    logic              dn_ok;

    logic              head_inrange;
    logic              hit_main;
    logic              hit_nb;
    logic              head_use_mem;
    acc_t              head_base;
    logic [BANK_AW-1:0] head_addr;

    logic               even_we;
    logic [BANK_AW-1:0] even_addr;
    logic [ACC_W-1:0]   even_data;
    logic               odd_we;
    logic [BANK_AW-1:0] odd_addr;
    logic [ACC_W-1:0]   odd_data;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop        = q_valid && (!s1_valid_reg || s1_adv);
    assign out_valid  = out_valid_reg;
    assign accidental = acc_reg;

    // ---- stage 1: resolve the entry and plan the writes ----
    always_comb
    begin
        if (!s1_inrange_reg)
            s1_acc = ACC_NONE;
        else if (s1_use_mem_reg)
            s1_acc = acc_t'(s1_note_reg[0] ? rd_odd_reg : rd_even_reg);
        else
            s1_acc = s1_base_reg;
    end

    assign dn_ok    = (s1_note_reg != '0);
    assign up_ok    = (({1'b0, s1_note_reg} + 1'b1) < (NOTE_W + 1)'(NOTE_COUNT));
    assign main_wen = s1_inrange_reg;

    always_comb
    begin
        nb_addr = s1_note_reg + 1'b1;
        nb_val  = ACC_NATURAL;
        nb_wen  = 1'b0;
        case (s1_acc)
            ACC_SHARP:
            begin
                nb_addr = s1_note_reg - 1'b1;
                nb_wen  = dn_ok;
            end
            ACC_FLAT:
            begin
                nb_wen = up_ok;
            end
            ACC_NATURAL:
            begin
                if (cfg.flat_count != '0)
                begin
                    nb_addr = s1_note_reg - 1'b1;
                    nb_val  = ACC_FLAT;
                    nb_wen  = dn_ok;
                end
                else
                begin
                    nb_val = ACC_SHARP;
                    nb_wen = up_ok;
                end
            end
            default:
            begin
                nb_wen = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (!s1_note_reg[0])
        begin
            even_we   = s1_adv && main_wen;
            even_addr = BANK_AW'(s1_note_reg >> 1);
            even_data = ACC_NONE;
            odd_we    = s1_adv && nb_wen;
            odd_addr  = BANK_AW'(nb_addr >> 1);
            odd_data  = nb_val;
        end
        else
        begin
            odd_we    = s1_adv && main_wen;
            odd_addr  = BANK_AW'(s1_note_reg >> 1);
            odd_data  = ACC_NONE;
            even_we   = s1_adv && nb_wen;
            even_addr = BANK_AW'(nb_addr >> 1);
            even_data = nb_val;
        end
    end

    // ---- head of queue: pick the source of its entry ----
    assign head_inrange = ({1'b0, head.note} < (NOTE_W + 1)'(NOTE_COUNT));
    assign head_addr    = BANK_AW'(head.note >> 1);
    // stage 1 always retires on a pop, so its writes land at the same edge
    assign hit_main     = s1_valid_reg && main_wen && (head.note == s1_note_reg);
    assign hit_nb       = s1_valid_reg && nb_wen && (head.note == nb_addr);

    always_comb
    begin
        head_use_mem = 1'b0;
        head_base    = ACC_NONE;
        if (head.reload)
            head_base = pattern_entry(key_of(cfg), head.note);
        else if (hit_main)
            head_base = ACC_NONE;
        else if (hit_nb)
            head_base = nb_val;
        else if (dirty_reg[head.note[MAP_AW-1:0]])
            head_use_mem = 1'b1;
        else
            head_base = pattern_entry(key_reg, head.note);
    end

    // ---- dirty bits: an entry written since the last reload ----
    always_comb
    begin
        dirty_next = dirty_reg;
        if (s1_adv)
        begin
            for (int i = 0; i < NOTE_COUNT; i++)
            begin
                if ((main_wen && (s1_note_reg == NOTE_W'(i))) ||
                    (nb_wen && (nb_addr == NOTE_W'(i))))
                begin
                    dirty_next[i] = 1'b1;
                end
            end
        end
        // reload clears every dirty bit, including those set by what retires at this edge
        if (pop && head.reload)
        begin
            dirty_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[even_addr] <= even_data;
        end
        if (odd_we)
        begin
            odd_mem[odd_addr] <= odd_data;
        end
        if (pop)
        begin
            rd_even_reg    <= even_mem[head_addr];
            rd_odd_reg     <= odd_mem[head_addr];
            s1_note_reg    <= head.note;
            s1_inrange_reg <= head_inrange;
            s1_use_mem_reg <= head_use_mem;
            s1_base_reg    <= head_base;
        end
        if (s1_adv)
        begin
            acc_reg <= s1_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg     <= '0;
            key_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dirty_reg <= dirty_next;
            if (pop && head.reload)
            begin
                key_reg <= key_of(cfg);
            end
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/notation_accidental_tracker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notation_accidental_tracker_top - accidental tracker for music notation
// Returns the accidental to print for each note, tracking key and measure.
// Path: queue, stage 1 registers, output register.
// Throughput: one beat per cycle while out_stall is low, set by the single
//   map read and two bank writes per note, neighbor write in the other bank.
// Reset: clears control state and key registers; the map has no clearing
//   pass, the first beat after reset reloads it from the key pattern.
// ----------------------------------------------------------------------------
module notation_accidental_tracker_top
    import nat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NOTE_W-1:0]    note_number,
    input  logic [MEASURE_W-1:0] measure_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ACC_W-1:0]     accidental,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    key_cfg_t cfg_reg;

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SHARP_COUNT: cfg_reg.sharp_count <= cfg_data;
                REG_FLAT_COUNT:  cfg_reg.flat_count  <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    nat_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .note_number   (note_number),
        .measure_index (measure_index),
        .q_full        (q_full),
        .in_stall      (in_stall),
        .push          (push),
        .push_item     (push_item)
    );

    nat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    nat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .cfg        (cfg_reg),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .accidental (accidental)
    );

endmodule

[rtl/core/nat_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_checker - port-level checks for the accidental tracker
// Watches reset, backpressure drain and the result beat at the top ports.
// ----------------------------------------------------------------------------
module nat_checker
    import nat_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ACC_W-1:0] accidental
);

    // nothing comes out and the input is not stalled while reset is held
    assert property (@(posedge clk) !rst_n ##1 !rst_n |-> !out_valid && !in_stall)
        else $error("result or stall during reset");

    // an unstalled output cycle drains the queue below full
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!out_stall) && $past(rst_n) |-> !in_stall)
        else $error("input stalled after an unstalled output cycle");

    // a rising out_valid must follow an accepted input beat, bar the listed cases
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2) ||
                             $past(in_valid && !in_stall, 3) ||
                             !$past(rst_n, 3) ||
                             $past(out_valid, 2) || $past(out_valid, 3) ||
                             $past(in_stall, 2) || $past(in_stall, 3) ||
                             $past(out_valid && !out_stall, 1) ||
                             $past(in_valid, 4))
        else $error("result without a preceding input beat");

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accidental))
        else $error("stalled result beat changed");

endmodule

bind notation_accidental_tracker_top nat_checker u_nat_checker (.*);
